/* src/antialiased_line_rasterizer_assert.svh */
// Assertion macros for the checker file.
`ifndef ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH
`define ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH

// Checked only outside reset.
`define ALR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) cond) \
    else $error("alr assertion failed");

// Checked during reset as well.
`define ALR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) cond) \
    else $error("alr assertion failed");

`endif

/* src/alr_pkg.sv */
package alr_pkg;

  // Item action codes.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Width of one color channel.
  localparam int COLOR_W = 8;

  // Classification attached to each queued item.
  typedef struct packed {
    logic start;
    logic steep;
    logic neg;
  } alr_cls_t;

endpackage

/* src/alr_if.sv */
interface line_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [7:0]            red_in;
  logic [7:0]            green_in;
  logic [7:0]            blue_in;
  logic [7:0]            alpha_in;

  modport source (output valid, action, start_x, start_y, end_x, end_y,
                  red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y,
                red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface pixel_out_if #(parameter int COORD_BITS = 12);
  logic                valid;
  logic                ready;
  logic [COORD_BITS:0] pixel_x;
  logic [COORD_BITS:0] pixel_y;
  logic [7:0]          red_out;
  logic [7:0]          green_out;
  logic [7:0]          blue_out;
  logic [7:0]          alpha_out;
  logic                last;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  alpha_out, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                alpha_out, last, output ready);
endinterface

/* src/alr_front.sv */
module alr_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  line_in_if.sink               in_ch,
  output logic                  q_valid,
  input  logic                  q_pop,
  output alr_pkg::alr_cls_t     q_cls,
  output logic [COORD_BITS-1:0] q_x0,
  output logic [COORD_BITS-1:0] q_y0,
  output logic [COORD_BITS-1:0] q_x1,
  output logic [COORD_BITS-1:0] q_y1,
  output logic [COORD_BITS-1:0] q_dx,
  output logic [COORD_BITS-1:0] q_ady,
  output logic [4*alr_pkg::COLOR_W-1:0] q_color
);
  import alr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int EW = 3 + 6 * C + 4 * COLOR_W;

  logic [C-1:0] adx, ady, a0, b0, a1, b1, c0, d0, c1, d1, dx, dmag;
  logic         steep;
  alr_cls_t     cls;
  logic [EW-1:0] entry;
  logic [EW-1:0] mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push;

  // Classify: swap axes for steep lines, then order by the major axis.
  always_comb begin
    adx = (in_ch.end_x > in_ch.start_x) ? in_ch.end_x - in_ch.start_x
                                        : in_ch.start_x - in_ch.end_x;
    ady = (in_ch.end_y > in_ch.start_y) ? in_ch.end_y - in_ch.start_y
                                        : in_ch.start_y - in_ch.end_y;
    steep = ady > adx;
    a0 = steep ? in_ch.start_y : in_ch.start_x;
    b0 = steep ? in_ch.start_x : in_ch.start_y;
    a1 = steep ? in_ch.end_y : in_ch.end_x;
    b1 = steep ? in_ch.end_x : in_ch.end_y;
    if (a0 > a1) begin
      c0 = a1; d0 = b1; c1 = a0; d1 = b0;
    end else begin
      c0 = a0; d0 = b0; c1 = a1; d1 = b1;
    end
    dx = c1 - c0;
    dmag = (d1 < d0) ? d0 - d1 : d1 - d0;
    cls.start = (in_ch.action == ACT_START);
    cls.steep = steep;
    cls.neg = d1 < d0;
    entry = {cls, c0, d0, c1, d1, dx, dmag,
             in_ch.red_in, in_ch.green_in, in_ch.blue_in, in_ch.alpha_in};
  end

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign {q_cls, q_x0, q_y0, q_x1, q_y1, q_dx, q_ady, q_color} = mem[rd_ptr];

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* src/alr_back.sv */
module alr_back #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  alr_pkg::alr_cls_t     q_cls,
  input  logic [COORD_BITS-1:0] q_x0,
  input  logic [COORD_BITS-1:0] q_y0,
  input  logic [COORD_BITS-1:0] q_x1,
  input  logic [COORD_BITS-1:0] q_y1,
  input  logic [COORD_BITS-1:0] q_dx,
  input  logic [COORD_BITS-1:0] q_ady,
  input  logic [4*alr_pkg::COLOR_W-1:0] q_color,
  pixel_out_if.source           out_ch
);
  import alr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int IW = C + F + 2;
  localparam int CW = $clog2(F + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT, ST_ADV} state_t;

  state_t state;
  logic steep, neg, active;
  logic [C-1:0] x0, y0, x1, y1, dx;
  logic [4*COLOR_W-1:0] color;
  logic signed [F+1:0] slope;
  logic signed [IW-1:0] intercept;
  logic [C:0] column, column_stop;
  logic [F:0] quo;
  logic [C:0] rem;
  logic [CW-1:0] cnt;
  logic [1:0] phase;

  logic [C:0] rem2;
  logic signed [F+1:0] slope_calc;
  logic [F-1:0] frac;
  logic [F:0] rfrac;
  logic [F+COLOR_W:0] near_p, far_p;
  logic [COLOR_W-1:0] alpha;
  logic [C:0] ipart, column_inc;
  logic out_free, emit;
  logic [C:0] major, minor;
  logic [COLOR_W-1:0] pix_alpha;
  logic pix_last;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign emit = out_free && ((state == ST_EMIT) || (state == ST_ADV));

  // Divider step and coverage split.
  always_comb begin
    rem2 = {rem[C-1:0], 1'b0};
    slope_calc = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    alpha = color[COLOR_W-1:0];
    frac = intercept[F-1:0];
    rfrac = {1'b1, {F{1'b0}}} - {1'b0, frac};
    near_p = alpha * rfrac;
    far_p = alpha * {1'b0, frac};
    ipart = intercept[C+F:F];
    column_inc = column + 1'b1;
  end

  // Pixel selection for the output register.
  always_comb begin
    major = {1'b0, x0};
    minor = {1'b0, y0};
    pix_alpha = '0;
    pix_last = 1'b0;
    if (state == ST_EMIT) begin
      case (phase)
        2'd0: begin
          pix_alpha = alpha >> 1;
        end
        2'd1: begin
          minor = {1'b0, y0} + 1'b1;
        end
        2'd2: begin
          major = {1'b0, x1};
          minor = {1'b0, y1};
          pix_alpha = alpha >> 1;
        end
        default: begin
          major = {1'b0, x1};
          minor = {1'b0, y1} + 1'b1;
          pix_last = !active;
        end
      endcase
    end else begin
      major = column;
      if (phase == 2'd0) begin
        minor = ipart;
        pix_alpha = near_p[F+COLOR_W-1:F];
      end else begin
        minor = ipart + 1'b1;
        pix_alpha = far_p[F+COLOR_W-1:F];
        pix_last = !(column_inc < column_stop);
      end
    end
  end

  // Sequencer, line state and output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.pixel_x <= steep ? minor : major;
      out_ch.pixel_y <= steep ? major : minor;
      out_ch.red_out <= color[4*COLOR_W-1:3*COLOR_W];
      out_ch.green_out <= color[3*COLOR_W-1:2*COLOR_W];
      out_ch.blue_out <= color[2*COLOR_W-1:COLOR_W];
      out_ch.alpha_out <= pix_alpha;
      out_ch.last <= pix_last;
    end
    if (rst) begin
      state <= ST_IDLE;
      out_ch.valid <= 1'b0;
      active <= 1'b0;
      steep <= 1'b0;
      column <= '0;
      column_stop <= '0;
      intercept <= '0;
      slope <= '0;
      color <= '0;
      phase <= 2'd0;
      cnt <= '0;
    end else begin
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          phase <= 2'd0;
          if (q_valid) begin
            if (q_cls.start) begin
              x0 <= q_x0;
              y0 <= q_y0;
              x1 <= q_x1;
              y1 <= q_y1;
              dx <= q_dx;
              steep <= q_cls.steep;
              neg <= q_cls.neg;
              color <= q_color;
              state <= ST_DIV;
              if (q_dx == '0) begin
                quo <= {1'b1, {F{1'b0}}};
                cnt <= '0;
              end else begin
                quo <= {{F{1'b0}}, (q_ady >= q_dx)};
                rem <= {1'b0, (q_ady >= q_dx) ? q_ady - q_dx : q_ady};
                cnt <= CW'(F);
              end
            end else if (active) begin
              state <= ST_ADV;
            end
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            slope <= slope_calc;
            intercept <= $signed({{(IW-C-F){1'b0}}, y0, {F{1'b0}}})
                         + IW'(slope_calc);
            column <= {1'b0, x0} + 1'b1;
            column_stop <= {1'b0, x1};
            active <= ({1'b0, x0} + 1'b1) < {1'b0, x1};
            state <= ST_EMIT;
          end else begin
            cnt <= cnt - 1'b1;
            if (rem2 >= {1'b0, dx}) begin
              rem <= rem2 - {1'b0, dx};
              quo <= {quo[F-1:0], 1'b1};
            end else begin
              rem <= rem2;
              quo <= {quo[F-1:0], 1'b0};
            end
          end
        end
        ST_EMIT: begin
          if (emit) begin
            phase <= phase + 1'b1;
            if (phase == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_ADV: begin
          if (emit) begin
            if (phase == 2'd0) begin
              phase <= 2'd1;
            end else begin
              intercept <= intercept + IW'(slope);
              column <= column_inc;
              active <= column_inc < column_stop;
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

/* src/antialiased_line_rasterizer.sv */
// Channel   Role     Transfer when          Payload
// line_in   sink     valid && ready         action, endpoints, color
// pix_out   source   valid && ready         pixel_x/y, color, alpha_out, last
//
// A start item is dequeued, then runs the bit-serial slope divider (with no
// division steps when the endpoints coincide), then makes four transfers.
// An advance item is dequeued and makes two pixel transfers, or is dequeued
// and dropped when no line is active.
// A two-entry queue decouples input from the back end; output stalls hold it.
// Reset is synchronous and leaves the block idle with no line active.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic         clk,
  input logic         rst,
  line_in_if.sink     line_in,
  pixel_out_if.source pix_out
);
  import alr_pkg::*;

  logic                  q_valid, q_pop;
  alr_cls_t              q_cls;
  logic [COORD_BITS-1:0] q_x0, q_y0, q_x1, q_y1, q_dx, q_ady;
  logic [4*COLOR_W-1:0]  q_color;

  alr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .in_ch(line_in),
    .q_valid(q_valid), .q_pop(q_pop), .q_cls(q_cls),
    .q_x0(q_x0), .q_y0(q_y0), .q_x1(q_x1), .q_y1(q_y1),
    .q_dx(q_dx), .q_ady(q_ady), .q_color(q_color)
  );

  alr_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_cls(q_cls),
    .q_x0(q_x0), .q_y0(q_y0), .q_x1(q_x1), .q_y1(q_y1),
    .q_dx(q_dx), .q_ady(q_ady), .q_color(q_color),
    .out_ch(pix_out)
  );
endmodule

/* src/alr_checker.sv */
module alr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COORD_BITS:0] pixel_x,
  input logic [COORD_BITS:0] pixel_y,
  input logic [7:0]          alpha_out
);
`include "antialiased_line_rasterizer_assert.svh"

  localparam logic [COORD_BITS:0] PIX_MAX = {1'b1, {COORD_BITS{1'b0}}};

  // No pixel is offered right after reset.
  `ALR_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid)
  // A stalled pixel holds its position and coverage.
  `ALR_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(alpha_out))
  // Pixel coordinates never exceed one past the coordinate range.
  `ALR_ASSERT(a_pix_range, out_valid |-> pixel_x <= PIX_MAX && pixel_y <= PIX_MAX)
endmodule

bind antialiased_line_rasterizer alr_checker #(.COORD_BITS(COORD_BITS)) u_alr_checker (
  .clk(clk), .rst(rst),
  .out_valid(pix_out.valid), .out_ready(pix_out.ready),
  .pixel_x(pix_out.pixel_x), .pixel_y(pix_out.pixel_y),
  .alpha_out(pix_out.alpha_out)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

import alr_pkg::*;

// One pixel as it leaves the rasterizer.
typedef struct packed {
  logic [12:0] px;
  logic [12:0] py;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last;
} pixel_t;

// Line tracker: follows the rasterizer state and holds the pixels still owed.
class line_tracker;
  localparam longint ONE = 64'sd1 << 16;

  bit          drawing;
  bit          steep;
  int unsigned col;
  int unsigned col_stop;
  longint      icept;
  longint      grad;
  logic [31:0] color;
  pixel_t      owed[$];
  int          mismatches;

  function void owe(longint major, longint minor, int unsigned a, bit lst);
    pixel_t p;
    logic [12:0] mj;
    logic [12:0] mn;
    mj = major[12:0];
    mn = minor[12:0];
    p.px = steep ? mn : mj;
    p.py = steep ? mj : mn;
    p.red = color[31:24];
    p.green = color[23:16];
    p.blue = color[15:8];
    p.alpha = a[7:0];
    p.last = lst;
    owed.insert(owed.size(), p);
  endfunction

  // Columns still to draw in the current line.
  function int remaining();
    return drawing ? int'(col_stop - col) : 0;
  endfunction

  // Note one accepted input transfer and work out the pixels it causes.
  function void note_input(logic act, int x0, int y0, int x1, int y1,
                           logic [31:0] rgba);
    int t;
    int dx;
    int dy;
    longint frac;
    longint ipart;
    int unsigned a;
    if (act == ACT_START) begin
      color = rgba;
      steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      grad = (dx == 0) ? ONE : (longint'(dy) * ONE) / longint'(dx);
      icept = longint'(y0) * ONE + grad;
      col = x0 + 1;
      col_stop = x1;
      drawing = col < col_stop;
      a = color[7:0];
      owe(x0, y0, a >> 1, 0);
      owe(x0, y0 + 1, 0, 0);
      owe(x1, y1, a >> 1, 0);
      owe(x1, y1 + 1, 0, !drawing);
    end else if (drawing) begin
      frac = icept & (ONE - 1);
      ipart = icept >>> 16;
      a = color[7:0];
      icept += grad;
      col = (col + 1) & 13'h1FFF;
      drawing = col < col_stop;
      owe(longint'(col) - 1, ipart, (a * (ONE - frac)) >> 16, 0);
      owe(longint'(col) - 1, ipart + 1, (a * frac) >> 16, !drawing);
    end
  endfunction

  // Compare one output transfer with the oldest owed pixel.
  function void check(pixel_t got);
    pixel_t exp_p;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel %p", got);
      return;
    end
    exp_p = owed.pop_front();
    if (got !== exp_p) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel mismatch: expected %p got %p", exp_p, got);
    end
  endfunction
endclass

module testbench;
  localparam int LIMIT = 1000000;

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  int   sent = 0;
  int   pix_seen = 0;
  bit   burst = 0;

  line_tracker lines = new();

  line_in_if #(12)   lin();
  pixel_out_if #(12) pout();

  antialiased_line_rasterizer u_top (
    .clk     (clk),
    .rst     (rst),
    .line_in (lin),
    .pix_out (pout)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("antialiased_line_rasterizer regression: fail");
      $finish;
    end
  end

  function int pick_gap();
    if ($urandom_range(0, 29) == 0)
      burst = !burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // Offer one item and wait for its transfer.
  task send(logic act, int x0, int y0, int x1, int y1, logic [31:0] rgba);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      lin.valid = 0;
    end
    @(negedge clk);
    lin.valid = 1;
    lin.action = act;
    lin.start_x = x0[11:0];
    lin.start_y = y0[11:0];
    lin.end_x = x1[11:0];
    lin.end_y = y1[11:0];
    {lin.red_in, lin.green_in, lin.blue_in, lin.alpha_in} = rgba;
    do @(posedge clk); while (!lin.ready);
    if (act == ACT_START || lines.drawing)
      sent++;
    lines.note_input(act, x0, y0, x1, y1, rgba);
  endtask

  // Start a line and advance it; extra advances past the end are ignored.
  task draw(int x0, int y0, int x1, int y1, logic [31:0] rgba, int adv);
    send(ACT_START, x0, y0, x1, y1, rgba);
    repeat (adv) send(ACT_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  function int near_to(int c);
    int v;
    v = c + $urandom_range(0, 48) - 24;
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // Receiver: random stalls, with one long hold-off so the input backs up.
  initial begin
    int gap;
    pout.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (pix_seen == 150) ? 400 : pick_gap();
      repeat (gap) begin
        @(negedge clk);
        pout.ready = 0;
      end
      @(negedge clk);
      pout.ready = 1;
      do @(posedge clk); while (!pout.valid);
      lines.check({pout.pixel_x, pout.pixel_y, pout.red_out, pout.green_out,
                   pout.blue_out, pout.alpha_out, pout.last});
      pix_seen++;
    end
  end

  initial begin
    int x0, y0, x1, y1, adv, k;
    lin.valid = 0;
    lin.action = ACT_START;
    lin.start_x = 0;
    lin.start_y = 0;
    lin.end_x = 0;
    lin.end_y = 0;
    {lin.red_in, lin.green_in, lin.blue_in, lin.alpha_in} = '0;
    repeat (3) @(negedge clk);
    rst = 0;

    // Directed lines: advance while idle, zero span, edges, steep, negative.
    send(ACT_ADVANCE, 1, 2, 3, 4, 32'hFFFFFFFF);
    draw(100, 200, 100, 200, 32'h12345680, 0);
    draw(4095, 4095, 4095, 4095, 32'hFFFFFFFF, 0);
    draw(0, 0, 4095, 0, 32'h000000FF, 5);
    draw(0, 4095, 4095, 0, 32'hA5A55A01, 3);
    draw(5, 0, 5, 10, 32'h00FF00FE, 9);
    draw(10, 20, 7, 3, 32'hFF000077, 16);
    draw(0, 0, 4, 4, 32'h0000FFFF, 3);
    draw(20, 5, 3, 9, 32'h5A5AA5C3, 18);
    draw(1, 1, 2, 1, 32'h01020300, 1);
    draw(4095, 0, 0, 4095, 32'hFFFFFF00, 2);

    // Random lines, mostly short and drawn out, some abandoned or overrun.
    while (sent < 480) begin
      x0 = $urandom_range(0, 4095);
      y0 = $urandom_range(0, 4095);
      if ($urandom_range(0, 15) == 0) begin
        x1 = $urandom_range(0, 4095);
        y1 = $urandom_range(0, 4095);
      end else begin
        x1 = near_to(x0);
        y1 = near_to(y0);
      end
      send(ACT_START, x0, y0, x1, y1, $urandom);
      k = $urandom_range(0, 9);
      adv = lines.remaining();
      if (k == 0)
        adv = (adv > 0) ? $urandom_range(0, adv - 1) : 0;
      else if (k == 1)
        adv = adv + $urandom_range(1, 3);
      if (adv > 40)
        adv = $urandom_range(0, 40);
      repeat (adv) send(ACT_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
    end

    @(negedge clk);
    lin.valid = 0;
    while (lines.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (lines.mismatches == 0 && lines.owed.size() == 0)
      $display("antialiased_line_rasterizer regression: pass");
    else
      $display("antialiased_line_rasterizer regression: fail");
    $finish;
  end
endmodule
